// File: src/scan_ring_buffer_angle_lookup_core_macros.svh
// Assertion macros for the scan ring buffer core.
// Clocked on clk, disabled during rst; no other dependencies.
`ifndef SCAN_RING_BUFFER_ANGLE_LOOKUP_CORE_MACROS_SVH
`define SCAN_RING_BUFFER_ANGLE_LOOKUP_CORE_MACROS_SVH

// Same-cycle implication.
`define SRBAL_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scan ring buffer: property violated");

// Next-cycle implication.
`define SRBAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scan ring buffer: property violated");

`endif

// File: src/srbal_pkg.sv
// Shared types, codes and constants of the scan ring buffer core.
// No dependencies; imported by every module of the block except srbal_ram.
package srbal_pkg;

  localparam int MAX_SCANS_DEF    = 8;
  localparam int MAX_READINGS_DEF = 2048;
  localparam int READING_BITS_DEF = 16;

  localparam int DEPTH_W   = 4;
  localparam int RES_W     = 7;
  localparam int ANGLE_W   = 16;
  localparam int READING_W = 16;
  localparam int DIST_W    = 16;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd8;
  localparam logic [RES_W-1:0]   RES_RESET   = 7'd100;
  localparam int RES_MIN   = 10;
  localparam int RES_MAX   = 100;
  localparam int HALF_TURN = 18000;

  localparam int DIV_BITS   = 4;
  localparam int DIV_CYCLES = ANGLE_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_BIT = 2;

  typedef enum logic {
    REG_DEPTH,
    REG_RESOLUTION
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_CLEAR,
    OP_LOOKUP
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EMPTY,
    ST_RANGE
  } status_t;

  typedef struct packed {
    op_t                        operation;
    logic [READING_W-1:0]       reading;
    logic                       scan_end;
    logic signed [ANGLE_W-1:0]  angle;
  } item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    status_t           status;
    logic              last_reading;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_EMPTY,
    S_DIV,
    S_ROUND,
    S_LREAD,
    S_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic pop;
    logic set_empty;
    logic div_step;
    logic round;
    logic lread;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

// File: src/scan_ring_buffer_angle_lookup_core.sv
// Top level of the scan ring buffer core: registers, controller, datapath.
// Depends on srbal_pkg, srbal_regs, srbal_ctrl, srbal_dpath and the macro header.
//
// Keeps up to scan_depth lidar scans in a ring held in one RAM, plus a spare
// slot for the scan being pushed. One item is worked on at a time; the result
// register lets the next item in while a result waits. Push and clear are
// latched and then executed; a pop reads the RAM and then loads the result,
// and a pop or lookup on an empty ring loads an empty status. A lookup runs
// the radix-16 angle divider, rounds, does the registered RAM read and loads
// the result. A stalled result holds the core until the result register is
// free. Writing scan_depth empties the ring and the pending scan.
`include "scan_ring_buffer_angle_lookup_core_macros.svh"

module scan_ring_buffer_angle_lookup_core
  import srbal_pkg::*;
#(
  parameter int MAX_SCANS    = MAX_SCANS_DEF,
  parameter int MAX_READINGS = MAX_READINGS_DEF,
  parameter int READING_BITS = READING_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [DEPTH_W-1:0] depth;
  logic [RES_W-1:0]   resolution;
  logic               depth_wr;
  cmd_t               cmd;
  stat_t              stat;

  srbal_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .depth      (depth),
    .resolution (resolution),
    .depth_wr   (depth_wr)
  );

  srbal_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  srbal_dpath #(
    .MAX_SCANS    (MAX_SCANS),
    .MAX_READINGS (MAX_READINGS),
    .READING_BITS (READING_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .depth        (depth),
    .resolution   (resolution),
    .depth_wr     (depth_wr),
    .cmd          (cmd),
    .stat         (stat)
  );

  `SRBAL_ASSERT_NEXT(a_busy_after_transfer, item_valid && !item_stall, item_stall)
  `SRBAL_ASSERT_IMPLY(a_error_zero, result_valid && result.status != ST_OK, result.distance == '0 && !result.last_reading)
  `SRBAL_ASSERT_IMPLY(a_load_when_free, cmd.out_load, !result_valid || !result_stall)
  `SRBAL_ASSERT_IMPLY(a_one_action, 1'b1, $onehot0({cmd.exec, cmd.pop, cmd.set_empty, cmd.div_step, cmd.round, cmd.lread}))

endmodule

// File: src/srbal_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srbal_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ren,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/srbal_regs.sv
// APB-style configuration registers: scan depth and angular resolution.
// Depends on srbal_pkg.
module srbal_regs
  import srbal_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [DEPTH_W-1:0]    depth,
  output logic [RES_W-1:0]      resolution,
  output logic                  depth_wr
);

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_IDX_BIT]);
  assign wr     = psel && penable && pwrite;
  assign depth_wr = wr && (idx == REG_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      depth      <= DEPTH_RESET;
      resolution <= RES_RESET;
    end else if (wr) begin
      case (idx)
        REG_DEPTH:      depth      <= pwdata[DEPTH_W-1:0];
        REG_RESOLUTION: resolution <= pwdata[RES_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEPTH:      prdata = CFG_DATA_W'(depth);
      REG_RESOLUTION: prdata = CFG_DATA_W'(resolution);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: src/srbal_ctrl.sv
// Controller state machine: sequences push, pop, clear and lookup transfers.
// Depends on srbal_pkg; drives commands to srbal_dpath.
module srbal_ctrl
  import srbal_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          case (stat.op)
            OP_POP:    state_next = stat.empty ? S_EMPTY : S_POP;
            OP_LOOKUP: state_next = stat.empty ? S_EMPTY : S_DIV;
            default:   state_next = S_EXEC;
          endcase
        end
      end
      S_EXEC:  state_next = S_IDLE;
      S_POP:   state_next = S_RESP;
      S_EMPTY: state_next = S_RESP;
      S_DIV:   state_next = stat.div_last ? S_ROUND : S_DIV;
      S_ROUND: state_next = S_LREAD;
      S_LREAD: state_next = S_RESP;
      S_RESP:  state_next = stat.out_free ? S_IDLE : S_RESP;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    case (state)
      S_IDLE: begin
        item_stall = 1'b0;
        cmd.load   = item_valid;
      end
      S_EXEC:  cmd.exec      = 1'b1;
      S_POP:   cmd.pop       = 1'b1;
      S_EMPTY: cmd.set_empty = 1'b1;
      S_DIV:   cmd.div_step  = 1'b1;
      S_ROUND: cmd.round     = 1'b1;
      S_LREAD: cmd.lread     = 1'b1;
      S_RESP:  cmd.out_load  = stat.out_free;
      default: ;
    endcase
  end

endmodule

// File: src/srbal_dpath.sv
// Datapath: ring pointers, scan store, angle divider and result register.
// Depends on srbal_pkg and srbal_ram; commanded by srbal_ctrl.
module srbal_dpath
  import srbal_pkg::*;
#(
  parameter int MAX_SCANS    = MAX_SCANS_DEF,
  parameter int MAX_READINGS = MAX_READINGS_DEF,
  parameter int READING_BITS = READING_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  item_t              item,
  input  logic               result_stall,
  output logic               result_valid,
  output result_t            result,
  input  logic [DEPTH_W-1:0] depth,
  input  logic [RES_W-1:0]   resolution,
  input  logic               depth_wr,
  input  cmd_t               cmd,
  output stat_t              stat
);

  localparam int SLOTS  = MAX_SCANS + 1;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int SUM_W  = SLOT_W + 1;
  localparam int POS_W  = $clog2(MAX_READINGS + 1);
  localparam int ADDR_W = $clog2(SLOTS * MAX_READINGS);
  localparam int WB     = READING_BITS > DIST_W ? READING_BITS : DIST_W;
  localparam int RES_N  = 2 ** RES_W;

  item_t               item_q;
  logic [SLOT_W-1:0]   oldest;
  logic [SLOT_W-1:0]   count;
  logic [POS_W-1:0]    wpos;
  logic [POS_W-1:0]    rpos;
  logic [POS_W-1:0]    wlen [SLOTS];

  logic [SLOT_W-1:0]   eff_depth;
  logic [SUM_W-1:0]    ring;
  logic [RES_W-1:0]    r_eff;
  logic [POS_W-1:0]    len_tab [RES_N];
  logic [POS_W-1:0]    len;
  logic [SLOT_W-1:0]   pend;
  logic [SLOT_W-1:0]   newest;
  logic [SLOT_W-1:0]   oldest_inc;
  logic                full;
  logic                room;
  logic [POS_W-1:0]    wpos_adv;
  logic                pop_last;

  logic [ANGLE_W-1:0]  dvd;
  logic [ANGLE_W-1:0]  quo;
  logic [RES_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] dcnt;
  logic [ANGLE_W-1:0]  dvd_next;
  logic [ANGLE_W-1:0]  quo_next;
  logic [RES_W-1:0]    rem_next;
  logic [RES_W:0]      trial;
  logic [ANGLE_W-1:0]  mag;
  logic [RES_W:0]      rem2;
  logic                round_up;
  logic [ANGLE_W:0]    q_round;
  logic [POS_W-1:0]    idx;
  logic                err;

  status_t             res_status;
  logic                res_zero;
  logic                res_last;

  logic                wen;
  logic [ADDR_W-1:0]   waddr;
  logic                ren;
  logic [ADDR_W-1:0]   raddr;
  logic [READING_BITS-1:0] wdata;
  logic [READING_BITS-1:0] rdata;

  function automatic logic [SLOT_W-1:0] wrap(input logic [SUM_W-1:0] a,
                                             input logic [SUM_W-1:0] r);
    return (a >= r) ? SLOT_W'(a - r) : SLOT_W'(a);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [SLOT_W-1:0] s,
                                                input logic [POS_W-1:0] p);
    return ADDR_W'(s) * ADDR_W'(MAX_READINGS) + ADDR_W'(p);
  endfunction

  for (genvar g = 0; g < RES_N; g++) begin : g_len
    localparam int ResEff = g < RES_MIN ? RES_MIN : (g > RES_MAX ? RES_MAX : g);
    localparam int LenRaw = HALF_TURN / ResEff + 1;
    localparam int LenCap = LenRaw > MAX_READINGS ? MAX_READINGS : LenRaw;
    assign len_tab[g] = POS_W'(LenCap);
  end

  always_comb begin
    if (depth == '0) begin
      eff_depth = SLOT_W'(1);
    end else if (32'(depth) > 32'(MAX_SCANS)) begin
      eff_depth = SLOT_W'(MAX_SCANS);
    end else begin
      eff_depth = SLOT_W'(depth);
    end
    if (32'(resolution) < 32'(RES_MIN)) begin
      r_eff = RES_W'(RES_MIN);
    end else if (32'(resolution) > 32'(RES_MAX)) begin
      r_eff = RES_W'(RES_MAX);
    end else begin
      r_eff = resolution;
    end
  end

  assign ring       = SUM_W'(eff_depth) + SUM_W'(1);
  assign len        = len_tab[resolution];
  assign pend       = wrap(SUM_W'(oldest) + SUM_W'(count), ring);
  assign newest     = wrap(SUM_W'(oldest) + SUM_W'(count) - SUM_W'(1), ring);
  assign oldest_inc = wrap(SUM_W'(oldest) + SUM_W'(1), ring);
  assign full       = count >= eff_depth;
  assign room       = wpos < len;
  assign wpos_adv   = room ? wpos + POS_W'(1) : wpos;
  assign pop_last   = (POS_W + 1)'(rpos) + (POS_W + 1)'(1) >= (POS_W + 1)'(len);

  // ring pointers and scan lengths
  always_ff @(posedge clk) begin
    if (rst || depth_wr) begin
      oldest <= '0;
      count  <= '0;
      wpos   <= '0;
      rpos   <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        wlen[s] <= '0;
      end
    end else begin
      if (cmd.exec && item_q.operation == OP_PUSH) begin
        if (item_q.scan_end) begin
          wlen[pend] <= wpos_adv;
          wpos       <= '0;
          if (full) begin
            oldest <= oldest_inc;
            rpos   <= '0;
          end else begin
            count <= count + SLOT_W'(1);
          end
        end else begin
          wpos <= wpos_adv;
        end
      end
      if (cmd.exec && item_q.operation == OP_CLEAR) begin
        oldest <= pend;
        count  <= '0;
        rpos   <= '0;
      end
      if (cmd.pop) begin
        if (pop_last) begin
          oldest <= oldest_inc;
          count  <= count - SLOT_W'(1);
          rpos   <= '0;
        end else begin
          rpos <= rpos + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
  end

  // radix-16 restoring divider of |angle| by resolution
  assign mag = item.angle[ANGLE_W-1] ? (~item.angle + ANGLE_W'(1)) : item.angle;

  always_comb begin
    dvd_next = dvd;
    quo_next = quo;
    rem_next = rem;
    trial    = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial    = {rem_next, dvd_next[ANGLE_W-1]};
      dvd_next = {dvd_next[ANGLE_W-2:0], 1'b0};
      if (trial >= {1'b0, r_eff}) begin
        rem_next = RES_W'(trial - {1'b0, r_eff});
        quo_next = {quo_next[ANGLE_W-2:0], 1'b1};
      end else begin
        rem_next = trial[RES_W-1:0];
        quo_next = {quo_next[ANGLE_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd  <= mag;
      quo  <= '0;
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      dvd  <= dvd_next;
      quo  <= quo_next;
      rem  <= rem_next;
      dcnt <= dcnt + DIV_CNT_W'(1);
    end
  end

  // round to nearest, ties to even
  assign rem2     = {rem, 1'b0};
  assign round_up = (rem2 > {1'b0, r_eff}) || ((rem2 == {1'b0, r_eff}) && quo[0]);
  assign q_round  = (ANGLE_W + 1)'(quo) + (ANGLE_W + 1)'(round_up);

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      idx <= POS_W'(q_round);
      err <= (item_q.angle[ANGLE_W-1] && q_round != '0) ||
             (q_round >= (ANGLE_W + 1)'(len));
    end
  end

  // scan store
  assign wen   = cmd.exec && item_q.operation == OP_PUSH && room;
  assign waddr = addr_of(pend, wpos);
  assign wdata = READING_BITS'(WB'(item_q.reading));
  assign ren   = cmd.pop || (cmd.lread && !err);
  assign raddr = cmd.pop ? addr_of(oldest, rpos) : addr_of(newest, idx);

  srbal_ram #(
    .WIDTH (READING_BITS),
    .DEPTH (SLOTS * MAX_READINGS)
  ) u_store (
    .clk   (clk),
    .wen   (wen),
    .waddr (waddr),
    .wdata (wdata),
    .ren   (ren),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      res_status <= ST_OK;
      res_zero   <= rpos >= wlen[oldest];
      res_last   <= pop_last;
    end else if (cmd.set_empty) begin
      res_status <= ST_EMPTY;
      res_zero   <= 1'b1;
      res_last   <= 1'b0;
    end else if (cmd.lread) begin
      res_status <= err ? ST_RANGE : ST_OK;
      res_zero   <= err || (idx >= wlen[newest]);
      res_last   <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.distance     <= res_zero ? '0 : DIST_W'(WB'(rdata));
      result.status       <= res_status;
      result.last_reading <= res_last;
    end
  end

  assign stat.op       = item.operation;
  assign stat.empty    = count == '0;
  assign stat.div_last = dcnt == DIV_CNT_W'(DIV_CYCLES - 1);
  assign stat.out_free = !result_valid || !result_stall;

endmodule
